[sv/tqps_pkg.sv]
// Shared types and codes of the two-queue priority server.
package tqps_pkg;

  localparam int unsigned TAG_W   = 16;
  localparam int unsigned LIMIT_W = 4;
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;
  localparam logic [LIMIT_W-1:0] RUN_MAX     = 4'd15;

  localparam logic [PADDR_W-1:0] ADDR_LIMIT = 2'd0;

  typedef enum logic [1:0] {
    OP_ENQ_GENERAL  = 2'd0,
    OP_ENQ_PRIORITY = 2'd1,
    OP_SERVE        = 2'd2,
    OP_FINISH       = 2'd3
  } opcode_e;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_REJECTED  = 3'd1;
  localparam logic [2:0] ST_SERVED_PRI = 3'd2;
  localparam logic [2:0] ST_SERVED_GEN = 3'd3;
  localparam logic [2:0] ST_BLOCKED   = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [TAG_W-1:0] client_tag;
  } in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [TAG_W-1:0] served_tag;
    logic             last;
  } out_t;

endpackage

[sv/tqps_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tqps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/two_queue_priority_server_with_limit_unit.sv]
// Two-queue priority server: general and priority tag FIFOs with a run limit.
//
// Commands arrive on the in channel (valid/ready), one item at a time; each
// gives one or more results on the out channel (valid/ready). Opcodes: enqueue
// general, enqueue priority, serve one, finish (drain everything, priority
// FIFO first, last set on the final result).
// Tags sit in two synchronous RAMs with registered read data; head, tail,
// count and the run counter sit in flops.
// Timing: a command's first result is held in a result register (a pop's tag
// in the RAM read register) and loaded into the output register once that is
// free; a pop reads the RAM at the accepting edge and the data is used in the
// following cycle. The next command is taken only back in idle, after that
// load. A finish then gives one result per cycle while the receiver takes
// them, each read issued as the previous result is loaded.
// The output register holds a result until it is taken; while the receiver
// stalls, the block finishes its current read and then waits.
// Reset empties both FIFOs, clears the run counter and sets the limit to 3;
// the RAM contents are not cleared and no entry is read before it is written.
// The limit register sits at APB address 0; the user must write it only while idle, as the block does not enforce this.
module two_queue_priority_server_with_limit_unit #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tqps_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output tqps_pkg::out_t               out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tqps_pkg::PADDR_W-1:0] paddr,
  input  logic [tqps_pkg::PDATA_W-1:0] pwdata,
  output logic [tqps_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import tqps_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e           state_q, state_d;
  out_t             res_q, res_d;
  logic             drain_q, drain_d;
  logic [PTR_W-1:0] gen_head_q, gen_head_d, gen_tail_q, gen_tail_d;
  logic [PTR_W-1:0] pri_head_q, pri_head_d, pri_tail_q, pri_tail_d;
  logic [CNT_W-1:0] gen_cnt_q, gen_cnt_d, pri_cnt_q, pri_cnt_d;
  logic [LIMIT_W-1:0] run_q, run_d, limit_q;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             gen_we, pri_we, gen_re, pri_re;
  logic [TAG_W-1:0] gen_rdata, pri_rdata, rd_tag;
  logic             rd_pri_q;
  logic             out_free, accept, cfg_we;
  logic             gen_any, pri_any, drain_one_left;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  tqps_ram #(.WIDTH(TAG_W), .DEPTH(QUEUE_DEPTH)) u_gen_ram (
    .clk_i  (clk_i),
    .we_i   (gen_we),
    .waddr_i(gen_tail_q),
    .wdata_i(in_data_i.client_tag),
    .re_i   (gen_re),
    .raddr_i(gen_head_q),
    .rdata_o(gen_rdata)
  );

  tqps_ram #(.WIDTH(TAG_W), .DEPTH(QUEUE_DEPTH)) u_pri_ram (
    .clk_i  (clk_i),
    .we_i   (pri_we),
    .waddr_i(pri_tail_q),
    .wdata_i(in_data_i.client_tag),
    .re_i   (pri_re),
    .raddr_i(pri_head_q),
    .rdata_o(pri_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign gen_any     = (gen_cnt_q != '0);
  assign pri_any     = (pri_cnt_q != '0);
  assign rd_tag      = rd_pri_q ? pri_rdata : gen_rdata;
  // after this pop nothing is left in either queue
  assign drain_one_left = ((pri_cnt_q == CNT_W'(1)) && !gen_any) ||
                          ((gen_cnt_q == CNT_W'(1)) && !pri_any);

  assign cfg_we = psel & penable & pwrite & pready & (paddr == ADDR_LIMIT);
  assign pready = 1'b1;
  assign prdata = {{(PDATA_W - LIMIT_W){1'b0}}, limit_q};

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    drain_d     = drain_q;
    gen_head_d  = gen_head_q;
    gen_tail_d  = gen_tail_q;
    gen_cnt_d   = gen_cnt_q;
    pri_head_d  = pri_head_q;
    pri_tail_d  = pri_tail_q;
    pri_cnt_d   = pri_cnt_q;
    run_d       = run_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    gen_we      = 1'b0;
    pri_we      = 1'b0;
    gen_re      = 1'b0;
    pri_re      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d   = '{status: ST_EMPTY, served_tag: '0, last: 1'b1};
          state_d = S_EMIT;
          unique case (opcode_e'(in_data_i.opcode))
            OP_ENQ_GENERAL: begin
              if (gen_cnt_q == CNT_FULL) begin
                res_d.status = ST_REJECTED;
              end else begin
                res_d.status = ST_ACCEPTED;
                gen_we       = 1'b1;
                gen_tail_d   = wrap_inc(gen_tail_q);
                gen_cnt_d    = gen_cnt_q + 1'b1;
              end
            end
            OP_ENQ_PRIORITY: begin
              if (pri_cnt_q == CNT_FULL) begin
                res_d.status = ST_REJECTED;
              end else begin
                res_d.status = ST_ACCEPTED;
                pri_we       = 1'b1;
                pri_tail_d   = wrap_inc(pri_tail_q);
                pri_cnt_d    = pri_cnt_q + 1'b1;
              end
            end
            OP_SERVE: begin
              if (pri_any && (run_q < limit_q)) begin
                res_d.status = ST_SERVED_PRI;
                pri_re       = 1'b1;
                pri_head_d   = wrap_inc(pri_head_q);
                pri_cnt_d    = pri_cnt_q - 1'b1;
                if (run_q != RUN_MAX) run_d = run_q + 1'b1;
                state_d      = S_RD;
              end else if (gen_any) begin
                res_d.status = ST_SERVED_GEN;
                gen_re       = 1'b1;
                gen_head_d   = wrap_inc(gen_head_q);
                gen_cnt_d    = gen_cnt_q - 1'b1;
                run_d        = '0;
                state_d      = S_RD;
              end else if (pri_any) begin
                res_d.status = ST_BLOCKED;
              end
            end
            OP_FINISH: begin
              run_d = '0;
              if (pri_any || gen_any) begin
                drain_d    = 1'b1;
                res_d.last = drain_one_left;
                state_d    = S_RD;
                if (pri_any) begin
                  res_d.status = ST_SERVED_PRI;
                  pri_re       = 1'b1;
                  pri_head_d   = wrap_inc(pri_head_q);
                  pri_cnt_d    = pri_cnt_q - 1'b1;
                end else begin
                  res_d.status = ST_SERVED_GEN;
                  gen_re       = 1'b1;
                  gen_head_d   = wrap_inc(gen_head_q);
                  gen_cnt_d    = gen_cnt_q - 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_RD, S_EMIT: begin
        // RAM data is valid from the cycle after the read until the next read
        if (state_q == S_RD) res_d.served_tag = rd_tag;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_d;
          if (drain_q && (pri_any || gen_any)) begin
            res_d.last = drain_one_left;
            state_d    = S_RD;
            if (pri_any) begin
              res_d.status = ST_SERVED_PRI;
              pri_re       = 1'b1;
              pri_head_d   = wrap_inc(pri_head_q);
              pri_cnt_d    = pri_cnt_q - 1'b1;
            end else begin
              res_d.status = ST_SERVED_GEN;
              gen_re       = 1'b1;
              gen_head_d   = wrap_inc(gen_head_q);
              gen_cnt_d    = gen_cnt_q - 1'b1;
            end
          end else begin
            drain_d = 1'b0;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_EMIT;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      drain_q     <= 1'b0;
      gen_head_q  <= '0;
      gen_tail_q  <= '0;
      gen_cnt_q   <= '0;
      pri_head_q  <= '0;
      pri_tail_q  <= '0;
      pri_cnt_q   <= '0;
      run_q       <= '0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
      rd_pri_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      drain_q     <= drain_d;
      gen_head_q  <= gen_head_d;
      gen_tail_q  <= gen_tail_d;
      gen_cnt_q   <= gen_cnt_d;
      pri_head_q  <= pri_head_d;
      pri_tail_q  <= pri_tail_d;
      pri_cnt_q   <= pri_cnt_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      if (pri_re || gen_re) rd_pri_q <= pri_re;
      if (cfg_we) limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  // a queue never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen_cnt_q <= CNT_FULL) && (pri_cnt_q <= CNT_FULL))
    else $error("queue count beyond depth");

  // a pop is only issued on a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen_re |-> gen_any) and (pri_re |-> pri_any))
    else $error("pop from empty queue");

  // waiting for read data only right after a RAM read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> $past(gen_re || pri_re))
    else $error("read state without a read");

  // an idle block has finished any drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !drain_q)
    else $error("drain left open");

endmodule
